@@ design/uer_pkg.sv @@
// Shared types, constants and helpers of the ultrasonic echo ranger.
// Used by every module of the block; depends on nothing.
package uer_pkg;

   // Timer width of the echo waits
   localparam int TIMEOUT_BITS = 16;
   localparam int TICK_W       = (TIMEOUT_BITS < 16) ? TIMEOUT_BITS : 16;
   localparam logic [32:0] TIMEOUT_MAX = (33'd1 << TIMEOUT_BITS) - 33'd1;

   // Trigger pulse shape, in ticks
   localparam logic [TICK_W:0] LOW_TICKS  = (TICK_W+1)'(2);
   localparam logic [TICK_W:0] HIGH_TICKS = (TICK_W+1)'(10);

   // Averaging and scaling
   localparam int SUM_W     = 24;
   localparam int CNT_W     = 8;
   localparam int DIST_W    = 19;
   localparam int DIV_CNT_W = $clog2(SUM_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);
   localparam int PROD_W    = SUM_W + DIST_W;
   localparam logic [DIST_W-1:0] SCALE_Q16    = 19'd288070;
   localparam logic [DIST_W-1:0] DIST_MAX     = 19'd288070;
   localparam logic [DIST_W-1:0] RANGE_MIN_Q8 = 19'd512;
   localparam logic [DIST_W-1:0] RANGE_MAX_Q8 = 19'd115200;

   // Stream and register port widths
   localparam int REQ_W      = 8;
   localparam int RSP_W      = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_RISE_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_HIGH_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

   localparam logic [15:0]      RISE_TIMEOUT_RST = 16'd10000;
   localparam logic [15:0]      HIGH_TIMEOUT_RST = 16'd30000;
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 8'd1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LOW  = 3'd1,
      PH_HIGH = 3'd2,
      PH_RISE = 3'd3,
      PH_FALL = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ENG_TICK     = 3'd0,
      ENG_DIV_LOAD = 3'd1,
      ENG_DIV      = 3'd2,
      ENG_MUL      = 3'd3,
      ENG_SCALE    = 3'd4,
      ENG_OUT      = 3'd5
   } eng_type;

   typedef struct packed {
      logic [15:0]      rise_timeout;
      logic [15:0]      high_timeout;
      logic [CNT_W-1:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic tick_clear;
      logic tick_one;
      logic tick_incr;
      logic burst_clear;
      logic sample_end;
      logic sample_good;
      logic div_load;
      logic div_step;
      logic mul_load;
      logic held_load;
      logic out_load;
      logic out_trig;
      logic out_busy;
      logic out_done;
   } cmd_type;

   typedef struct packed {
      logic low_last;
      logic high_last;
      logic rise_expired;
      logic fall_expired;
      logic burst_last;
      logic div_last;
   } status_type;

   // Clamp a timeout register to what the tick timer can count
   function automatic logic [TICK_W-1:0] timeout_limit(input logic [15:0] value);
      if ({17'd0, value} < TIMEOUT_MAX) begin
         return TICK_W'(value);
      end
      return TICK_W'(TIMEOUT_MAX);
   endfunction

endpackage

@@ design/uer_csr.sv @@
// Configuration registers of the echo ranger behind a simple APB-style port.
// Depends on uer_pkg.
module uer_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [uer_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [uer_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [uer_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output uer_pkg::cfg_type                 cfg
);
   import uer_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RISE_TIMEOUT: cfg_in.rise_timeout = csr_pwdata[15:0];
            REG_HIGH_TIMEOUT: cfg_in.high_timeout = csr_pwdata[15:0];
            REG_SAMPLE_COUNT: cfg_in.sample_count = csr_pwdata[CNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RISE_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.rise_timeout);
         REG_HIGH_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.high_timeout);
         REG_SAMPLE_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.sample_count);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_timeout <= RISE_TIMEOUT_RST;
         cfg_ff.high_timeout <= HIGH_TIMEOUT_RST;
         cfg_ff.sample_count <= SAMPLE_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/uer_dp.sv @@
// Datapath of the echo ranger: tick timer, burst accumulators, serial divider,
// scaling multiplier and the result register. Depends on uer_pkg.
module uer_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  uer_pkg::cfg_type            cfg,
   input  uer_pkg::cmd_type            cmd,
   output uer_pkg::status_type         status,
   output logic [uer_pkg::RSP_W-1:0]   rsp_tdata
);
   import uer_pkg::*;

   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     taken_ff, taken_in;
   logic [CNT_W-1:0]     good_ff, good_in;
   logic [DIST_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [RSP_W-1:0]     rsp_ff, rsp_in;

   logic [TICK_W:0]      tick_plus;
   logic [TICK_W-1:0]    rise_lim;
   logic [TICK_W-1:0]    high_lim;
   logic [SUM_W:0]       sum_add;
   logic [CNT_W-1:0]     taken_next;
   logic [CNT_W:0]       rem_shift;
   logic                 rem_fit;
   logic [PROD_W-17:0]   scaled;
   logic                 ok;
   logic [DIST_W-1:0]    dist_q8;
   logic                 far_out;

   assign tick_plus  = {1'b0, ticks_ff} + (TICK_W+1)'(1);
   assign rise_lim   = timeout_limit(cfg.rise_timeout);
   assign high_lim   = timeout_limit(cfg.high_timeout);
   assign taken_next = taken_ff + CNT_W'(1);
   assign sum_add    = {1'b0, sum_ff} + (SUM_W+1)'(ticks_ff);

   assign status.low_last     = tick_plus >= LOW_TICKS;
   assign status.high_last    = tick_plus >= HIGH_TICKS;
   assign status.rise_expired = tick_plus >= {1'b0, rise_lim};
   assign status.fall_expired = ticks_ff >= high_lim;
   assign status.burst_last   = taken_next >= cfg.sample_count;
   assign status.div_last     = div_cnt_ff == DIV_LAST;

   // Tick timer and burst accumulators
   always_comb begin
      ticks_in = ticks_ff;
      sum_in   = sum_ff;
      taken_in = taken_ff;
      good_in  = good_ff;
      if (cmd.tick_clear) begin
         ticks_in = '0;
      end else if (cmd.tick_one) begin
         ticks_in = TICK_W'(1);
      end else if (cmd.tick_incr) begin
         ticks_in = tick_plus[TICK_W-1:0];
      end
      if (cmd.burst_clear) begin
         sum_in   = '0;
         taken_in = '0;
         good_in  = '0;
      end else if (cmd.sample_end) begin
         taken_in = taken_next;
         if (cmd.sample_good) begin
            // saturate the width sum
            sum_in  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            good_in = good_ff + CNT_W'(1);
         end
      end
   end

   // Restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_fit   = rem_shift >= {1'b0, good_ff};

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         rem_in     = '0;
         quot_in    = sum_ff;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = rem_fit ? CNT_W'(rem_shift - {1'b0, good_ff}) : rem_shift[CNT_W-1:0];
         quot_in    = {quot_ff[SUM_W-2:0], rem_fit};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Scale average to 1/256 cm, then clamp
   assign prod_in = cmd.mul_load ? PROD_W'(quot_ff) * PROD_W'(SCALE_Q16) : prod_ff;
   assign scaled  = prod_ff[PROD_W-1:16];

   always_comb begin
      held_in = held_ff;
      if (cmd.held_load) begin
         if (good_ff == '0) begin
            held_in = '0;
         end else if (scaled > (PROD_W-16)'(DIST_MAX)) begin
            held_in = DIST_MAX;
         end else begin
            held_in = scaled[DIST_W-1:0];
         end
      end
   end

   // Result fields
   assign ok      = !cmd.out_busy && (good_ff != '0);
   assign dist_q8 = ok ? held_ff : '0;
   assign far_out = ok && ((dist_q8 < RANGE_MIN_Q8) || (dist_q8 > RANGE_MAX_Q8));

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in = {(cmd.out_busy ? {CNT_W{1'b0}} : good_ff), dist_q8, far_out, ok,
                   cmd.out_done, cmd.out_busy, cmd.out_trig};
      end
   end

   assign rsp_tdata = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         sum_ff   <= '0;
         taken_ff <= '0;
         good_ff  <= '0;
         held_ff  <= '0;
      end else begin
         ticks_ff <= ticks_in;
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
         good_ff  <= good_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      div_cnt_ff <= div_cnt_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ design/uer_ctrl.sv @@
// Controller of the echo ranger: measurement phase sequencer, post-burst
// engine sequence and stream handshakes. Depends on uer_pkg.
module uer_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  echo_level,
   input  logic                  start_request,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  uer_pkg::status_type   status,
   output uer_pkg::cmd_type      cmd
);
   import uer_pkg::*;

   phase_type phase_ff, phase_in;
   eng_type   eng_ff, eng_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      end_smp;
   logic      end_good;

   assign req_tready = (eng_ff == ENG_TICK) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      phase_in = phase_ff;
      eng_in   = eng_ff;
      end_smp  = 1'b0;
      end_good = 1'b0;
      case (eng_ff)
         ENG_TICK: begin
            if (accept) begin
               cmd.out_load = 1'b1;
               case (phase_ff)
                  PH_IDLE: begin
                     if (start_request) begin
                        phase_in        = PH_LOW;
                        cmd.tick_clear  = 1'b1;
                        cmd.burst_clear = 1'b1;
                     end
                  end
                  PH_LOW: begin
                     if (status.low_last) begin
                        phase_in       = PH_HIGH;
                        cmd.tick_clear = 1'b1;
                     end else begin
                        cmd.tick_incr = 1'b1;
                     end
                  end
                  PH_HIGH: begin
                     cmd.out_trig = 1'b1;
                     if (status.high_last) begin
                        phase_in       = PH_RISE;
                        cmd.tick_clear = 1'b1;
                     end else begin
                        cmd.tick_incr = 1'b1;
                     end
                  end
                  PH_RISE: begin
                     if (echo_level) begin
                        phase_in     = PH_FALL;
                        cmd.tick_one = 1'b1;
                     end else if (status.rise_expired) begin
                        end_smp = 1'b1;
                     end else begin
                        cmd.tick_incr = 1'b1;
                     end
                  end
                  PH_FALL: begin
                     if (!echo_level) begin
                        end_smp  = 1'b1;
                        end_good = 1'b1;
                     end else if (status.fall_expired) begin
                        end_smp = 1'b1;
                     end else begin
                        cmd.tick_incr = 1'b1;
                     end
                  end
                  default: begin
                     phase_in       = PH_IDLE;
                     cmd.tick_clear = 1'b1;
                  end
               endcase
               if (end_smp) begin
                  cmd.sample_end  = 1'b1;
                  cmd.sample_good = end_good;
                  cmd.tick_clear  = 1'b1;
                  if (status.burst_last) begin
                     // hold the result until the average is ready
                     phase_in     = PH_IDLE;
                     cmd.out_load = 1'b0;
                     eng_in       = ENG_DIV_LOAD;
                  end else begin
                     phase_in = PH_LOW;
                  end
               end
               cmd.out_busy = phase_in != PH_IDLE;
            end
         end
         ENG_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            eng_in       = ENG_DIV;
         end
         ENG_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               eng_in = ENG_MUL;
            end
         end
         ENG_MUL: begin
            cmd.mul_load = 1'b1;
            eng_in       = ENG_SCALE;
         end
         ENG_SCALE: begin
            cmd.held_load = 1'b1;
            eng_in        = ENG_OUT;
         end
         ENG_OUT: begin
            cmd.out_load = 1'b1;
            cmd.out_done = 1'b1;
            eng_in       = ENG_TICK;
         end
         default: begin
            eng_in = ENG_TICK;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         eng_ff       <= ENG_TICK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         eng_ff       <= eng_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: trigger/echo sequencing per
// microsecond tick, burst averaging and distance scaling.
// Depends on uer_pkg, uer_csr, uer_ctrl and uer_dp.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  echo_level, start_request
//   rsp_      out        rsp_tvalid/rsp_tready  one result per request
//   csr_      in/out     psel/penable/pready    three timing/burst registers
//
// A request that does not close a burst loads its result into the output register
// when it is taken; a new request is taken once the output register is empty or in
// the cycle its result leaves. The request that closes a burst runs through the
// accept cycle, a divider load, a restoring divide (one quotient bit per cycle),
// a multiply stage, a clamp stage and the output load.
// Reset is synchronous, active high; it clears the phase, the accumulators
// and the held distance, and loads the register defaults.
// A stalled result holds the output register and blocks further requests.
module ultrasonic_echo_ranger (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] echo_level, [1] start_request, [7:2] zero
   input  logic [uer_pkg::REQ_W-1:0]        req_tdata,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] trigger_level, [1] busy_res, [2] done_res, [3] reading_ok,
   // [4] out_of_range, [23:5] distance_q8, [31:24] valid_count
   output logic [uer_pkg::RSP_W-1:0]        rsp_tdata,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [uer_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [uer_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [uer_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import uer_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Register file
   uer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Phase sequencer and handshakes
   uer_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .echo_level    (req_tdata[0]),
      .start_request (req_tdata[1]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .status        (status),
      .cmd           (cmd)
   );

   // Timers, accumulators, divider and result register
   uer_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // Trigger is driven only while a burst runs
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("trigger high outside a burst");

   // A finished burst reports idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done while busy");

   // A reading needs at least one valid sample
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[31:24] != 8'd0)
      else $error("reading without valid samples");

   // Without a reading, distance and range flag are zero
   a_no_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> (rsp_tdata[23:5] == 19'd0) && !rsp_tdata[4])
      else $error("distance shown without a reading");
`endif

endmodule

@@ tb/sv/ultrasonic_echo_ranger_test.sv @@
// Self-checking bench for ultrasonic_echo_ranger: drives microsecond ticks as
// requests, predicts every result tick and compares it field by field.
// Depends on uer_pkg and the ultrasonic_echo_ranger top level.
module ultrasonic_echo_ranger_test;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_TICKS_PER_PHASE = 25;
   localparam int unsigned SUM_CAP = (1 << SUM_W) - 1;

   // One result tick, packed as on rsp_tdata (trigger in bit 0)
   typedef struct packed {
      logic [CNT_W-1:0]  samples;
      logic [DIST_W-1:0] distance;
      logic              out_of_range;
      logic              reading_ok;
      logic              done;
      logic              busy;
      logic              trigger;
   } reading_type;

   typedef struct {
      logic echo;
      logic start;
   } tick_type;

   typedef enum {PULSE_GOOD, PULSE_LATE, PULSE_LONG} pulse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ultrasonic_echo_ranger dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Pending request ticks and the result ticks they must produce
   tick_type    pending_ticks[$];
   reading_type expected_readings[$];
   int          queued_total = 0;
   int          issued_count = 0;
   int          accepted_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   // Ranger state and register copy, as the block holds them after reset
   phase_type         ph = PH_IDLE;
   int unsigned       ph_ticks = 0;
   int unsigned       width_sum = 0;
   logic [CNT_W-1:0]  taken_count = '0;
   logic [CNT_W-1:0]  good_count = '0;
   logic [DIST_W-1:0] held_distance = '0;
   logic [15:0]       cfg_rise = RISE_TIMEOUT_RST;
   logic [15:0]       cfg_high = HIGH_TIMEOUT_RST;
   logic [CNT_W-1:0]  cfg_count = SAMPLE_COUNT_RST;

   initial begin
      forever #6 clock = ~clock;
   end

   // The tick timer cannot count past its own width
   function automatic int unsigned wait_limit(input logic [15:0] value);
      return (value < TIMEOUT_MAX) ? 32'(value) : TIMEOUT_MAX[31:0];
   endfunction

   // Random pin level
   function automatic logic coin();
      return $urandom_range(1) != 0;
   endfunction

   // Close one measurement; on the last one of the burst, average and scale
   task automatic close_sample(input bit ok, input int unsigned width,
                               output bit burst_done);
      longint unsigned avg;
      longint unsigned scaled;
      if (ok) begin
         width_sum  = (width_sum + width > SUM_CAP) ? SUM_CAP : width_sum + width;
         good_count = good_count + CNT_W'(1);
      end
      taken_count = taken_count + CNT_W'(1);
      ph_ticks    = 0;
      burst_done  = 1'b0;
      if (taken_count >= cfg_count) begin
         held_distance = '0;
         if (good_count != 0) begin
            avg    = 64'(width_sum / good_count);
            scaled = (avg * 64'(SCALE_Q16)) >> 16;
            held_distance = (scaled > DIST_MAX) ? DIST_MAX : scaled[DIST_W-1:0];
         end
         ph = PH_IDLE;
         burst_done = 1'b1;
      end else begin
         ph = PH_LOW;
      end
   endtask

   // Advance the ranger by one microsecond tick and form its result tick
   task automatic advance_ranger(input logic echo, input logic start,
                                 output reading_type r);
      bit trig;
      bit done;
      bit ok;
      trig = 1'b0;
      done = 1'b0;
      case (ph)
         PH_IDLE: begin
            if (start) begin
               ph          = PH_LOW;
               ph_ticks    = 0;
               width_sum   = 0;
               taken_count = '0;
               good_count  = '0;
            end
         end
         PH_LOW: begin
            ph_ticks++;
            if (ph_ticks >= LOW_TICKS) begin
               ph = PH_HIGH;
               ph_ticks = 0;
            end
         end
         PH_HIGH: begin
            trig = 1'b1;
            ph_ticks++;
            if (ph_ticks >= HIGH_TICKS) begin
               ph = PH_RISE;
               ph_ticks = 0;
            end
         end
         PH_RISE: begin
            if (echo) begin
               ph = PH_FALL;
               ph_ticks = 1;
            end else begin
               ph_ticks++;
               if (ph_ticks >= wait_limit(cfg_rise)) close_sample(1'b0, 0, done);
            end
         end
         PH_FALL: begin
            if (!echo) begin
               close_sample(ph_ticks != 0, ph_ticks, done);
            end else if (ph_ticks >= wait_limit(cfg_high)) begin
               close_sample(1'b0, 0, done);
            end else begin
               ph_ticks++;
            end
         end
         default: begin
            ph = PH_IDLE;
            ph_ticks = 0;
         end
      endcase
      ok             = (ph == PH_IDLE) && (good_count != 0);
      r.trigger      = trig;
      r.busy         = (ph != PH_IDLE);
      r.done         = done;
      r.reading_ok   = ok;
      r.distance     = ok ? held_distance : '0;
      r.out_of_range = ok && (r.distance < RANGE_MIN_Q8 || r.distance > RANGE_MAX_Q8);
      r.samples      = (ph != PH_IDLE) ? '0 : good_count;
   endtask

   task automatic note_mismatch(input string what, input reading_type want,
                                input reading_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at cycle %0d: expected trig %0d busy %0d done %0d ok %0d oor %0d",
                  what, cycle_count, want.trigger, want.busy, want.done,
                  want.reading_ok, want.out_of_range);
         $display("   dist %0d count %0d; got trig %0d busy %0d done %0d ok %0d oor %0d",
                  want.distance, want.samples, got.trigger, got.busy, got.done,
                  got.reading_ok, got.out_of_range);
         $display("   dist %0d count %0d", got.distance, got.samples);
      end
   endtask

   // Request driver: hold a request until taken, then load the next one or idle
   always @(negedge clock) begin : drive_requests
      tick_type next_tick;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (accepted_count == issued_count) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_tick = pending_ticks.pop_front();
            req_tdata  <= REQ_W'({next_tick.start, next_tick.echo});
            req_tvalid <= 1'b1;
            issued_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: stall at random
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Monitor: predict on each taken request, check each taken result
   always @(posedge clock) begin : watch_channels
      reading_type want;
      reading_type got;
      if (!reset) begin
         // Predict first, so a same-edge result still meets the oldest entry
         if (req_tvalid && req_tready) begin
            advance_ranger(req_tdata[0], req_tdata[1], want);
            expected_readings.push_back(want);
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_readings.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_readings.pop_front();
               if (got.trigger !== want.trigger || got.busy !== want.busy ||
                   got.done !== want.done || got.reading_ok !== want.reading_ok ||
                   got.out_of_range !== want.out_of_range ||
                   got.distance !== want.distance || got.samples !== want.samples)
                  note_mismatch("result mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ultrasonic_echo_ranger test failed");
         $finish;
      end
   end

   task automatic push_tick(input logic echo, input logic start);
      pending_ticks.push_back('{echo: echo, start: start});
      queued_total++;
   endtask

   // Wait until every request is taken and every result has come back
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || accepted_count != issued_count ||
             expected_readings.size() != 0)
         @(negedge clock);
   endtask

   // Drain, then feed quiet ticks until any broken burst has run out
   task automatic finish_bursts();
      wait_drained();
      while (ph != PH_IDLE) begin
         push_tick(1'b0, 1'b0);
         wait_drained();
      end
   endtask

   // Two-phase register write; update the predicted copy once it lands
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_RISE_TIMEOUT: cfg_rise  = value[15:0];
         REG_HIGH_TIMEOUT: cfg_high  = value[15:0];
         REG_SAMPLE_COUNT: cfg_count = value[CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic queue_burst_start();
      repeat ($urandom_range(2)) push_tick(coin(), 1'b0);
      push_tick(coin(), 1'b1);
   endtask

   // One measurement: trigger ticks, echo wait of gap ticks, then the echo (a late one waits out the rise limit)
   task automatic queue_sample(input pulse_type kind, input int gap, input int width);
      int rise_lim;
      int high_lim;
      rise_lim = wait_limit(cfg_rise);
      high_lim = wait_limit(cfg_high);
      // echo and start are ignored while the trigger is sequenced
      repeat (LOW_TICKS + HIGH_TICKS) push_tick(coin(), coin());
      case (kind)
         PULSE_LATE: repeat ((rise_lim == 0) ? 1 : rise_lim)
            push_tick(1'b0, coin());
         PULSE_LONG: begin
            repeat (gap) push_tick(1'b0, coin());
            repeat (((high_lim == 0) ? 1 : high_lim) + 1) push_tick(1'b1, coin());
         end
         default: begin
            repeat (gap) push_tick(1'b0, coin());
            repeat (width) push_tick(1'b1, coin());
            push_tick(1'b0, coin());
         end
      endcase
   endtask

   // Mostly well-formed measurements, some timeouts, some raw noise
   task automatic queue_random_burst(input int max_width);
      int rise_lim;
      int high_lim;
      int gap;
      int roll;
      rise_lim = wait_limit(cfg_rise);
      high_lim = wait_limit(cfg_high);
      queue_burst_start();
      repeat ((cfg_count == 0) ? 1 : cfg_count) begin
         roll = $urandom_range(99);
         gap  = (rise_lim == 0) ? 0 : $urandom_range((rise_lim > 16) ? 15 : rise_lim - 1);
         if (roll < 8) begin
            repeat ($urandom_range(1, 8)) push_tick(coin(), coin());
         end else if (roll < 22) begin
            queue_sample(PULSE_LATE, 0, 0);
         end else if (roll < 34 && high_lim < 200) begin
            queue_sample(PULSE_LONG, gap, 0);
         end else begin
            queue_sample(PULSE_GOOD, gap, $urandom_range(1, (high_lim == 0) ? 1 :
                         ((high_lim < max_width) ? high_lim : max_width)));
         end
      end
   endtask

   initial begin : run_stimulus
      int send_plan[4];
      int stall_plan[4];
      int goal;
      int roll;
      send_plan  = '{0, 79, 0, 26};
      stall_plan = '{0, 0, 79, 26};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // In-range reading at the largest timeouts; echoes while idle do nothing
      write_csr(REG_RISE_TIMEOUT, 32'hFFFF);
      write_csr(REG_HIGH_TIMEOUT, 32'hFFFF);
      write_csr(REG_SAMPLE_COUNT, 32'd1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b0);
      queue_burst_start();
      queue_sample(PULSE_GOOD, 7, 117);     // first width inside the range
      finish_bursts();

      // A missed echo leaves no reading and clears the held fields
      write_csr(REG_RISE_TIMEOUT, 32'd8);
      queue_burst_start();
      queue_sample(PULSE_LATE, 0, 0);
      finish_bursts();

      // Three-sample burst with one good, one long and one late echo;
      // hold off the sender mid-burst until every result is back
      write_csr(REG_RISE_TIMEOUT, 32'd4);
      write_csr(REG_HIGH_TIMEOUT, 32'd6);
      write_csr(REG_SAMPLE_COUNT, 32'd3);
      queue_burst_start();
      queue_sample(PULSE_GOOD, 3, 6);
      wait_drained();
      queue_sample(PULSE_LONG, 1, 0);
      queue_sample(PULSE_LATE, 0, 0);
      finish_bursts();

      // Zero timeouts give up on the first tick of a wait; zero count acts as one
      write_csr(REG_RISE_TIMEOUT, 32'd0);
      write_csr(REG_HIGH_TIMEOUT, 32'd0);
      write_csr(REG_SAMPLE_COUNT, 32'd0);
      queue_burst_start();
      queue_sample(PULSE_GOOD, 0, 1);
      queue_burst_start();
      queue_sample(PULSE_LATE, 0, 0);
      queue_burst_start();
      queue_sample(PULSE_LONG, 0, 0);
      finish_bursts();

      // Many-sample burst, kept cheap with the shortest waits
      write_csr(REG_RISE_TIMEOUT, 32'd1);
      write_csr(REG_HIGH_TIMEOUT, 32'd3);
      write_csr(REG_SAMPLE_COUNT, 32'd5);
      queue_random_burst(3);
      finish_bursts();

      // Random bursts under each idling pattern, new settings for every burst
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_plan[p];
         stall_pct     = stall_plan[p];
         goal = queued_total + RANDOM_TICKS_PER_PHASE;
         while (queued_total < goal) begin
            finish_bursts();
            write_csr(REG_RISE_TIMEOUT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
            roll = $urandom_range(99);
            write_csr(REG_HIGH_TIMEOUT, (roll < 10) ? 0 :
                      (roll < 35) ? $urandom_range(120, 300) : $urandom_range(1, 12));
            write_csr(REG_SAMPLE_COUNT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3));
            queue_random_burst(10);
         end
      end

      // Drain, then let the closing divide and any stray result show up
      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("ultrasonic_echo_ranger test passed");
      end else begin
         $display("ultrasonic_echo_ranger test failed");
      end
      $finish;
   end

endmodule
